/* rtl/isrt_pkg.sv */
// isrt_pkg: shared types and default parameter values for the insertion sorter
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package isrt_pkg;

	// default store depth and value width
	localparam int DEPTH_DEF      = 32;
	localparam int DATA_WIDTH_DEF = 32;

	// commands from controller to datapath
	typedef struct packed {
		logic insert;   // put the incoming item into the sorted cells
		logic shift;    // move the smallest cell out to the result registers
	} isrt_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last_one; // exactly one stored value remains
	} isrt_status_t;

endpackage

`default_nettype wire

/* rtl/isrt_ctrl.sv */
// isrt_ctrl: two-state controller that sequences loading and draining of the cells
// depends on isrt_pkg for the command and status types
`timescale 1ns / 1ps
`default_nettype none

module isrt_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  last,
	input  wire isrt_pkg::isrt_status_t status,
	output      isrt_pkg::isrt_cmd_t    cmd,
	output      logic                  busy
);
	import isrt_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic accept;

	// item handshake
	assign busy   = (state_q == ST_DRAIN);
	assign accept = start & ~busy;

	// command decode
	assign cmd.insert = accept;
	assign cmd.shift  = (state_q == ST_DRAIN);

	// next state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (status.last_one) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/isrt_dp.sv */
// isrt_dp: compare-and-shift cell array, fill count, drop flag and result registers
// depends on isrt_pkg for the command and status types
`timescale 1ns / 1ps
`default_nettype none

module isrt_dp #(
	parameter int DEPTH      = isrt_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = isrt_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire isrt_pkg::isrt_cmd_t          cmd,
	input  wire logic signed [DATA_WIDTH-1:0] value,
	output      isrt_pkg::isrt_status_t       status,
	output      logic                         strobe,
	output      logic signed [DATA_WIDTH-1:0] sorted_value,
	output      logic                         end_of_run,
	output      logic                         overflow
);
	import isrt_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic signed [DATA_WIDTH-1:0] cell_ins [DEPTH];
	logic [DEPTH-1:0]             gt;
	logic [CW-1:0]                count_q;
	logic                         dropped_q;
	logic                         full;
	logic                         strobe_q;
	logic signed [DATA_WIDTH-1:0] sorted_value_q;
	logic                         end_of_run_q;
	logic                         overflow_q;

	assign full            = (count_q == CW'(DEPTH));
	assign status.last_one = (count_q == CW'(1));

	// per-cell compare: occupied cells holding a value strictly above the new one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CW'(i) < count_q) && (cell_q[i] > value);
		end
	end

	// insertion network: cells above the slot take their lower neighbour,
	// the slot takes the new value, equal values stay ahead of it
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				cell_ins[i] = cell_q[(i > 0) ? i - 1 : 0];
			end else if (gt[i] || count_q == CW'(i)) begin
				cell_ins[i] = value;
			end else begin
				cell_ins[i] = cell_q[i];
			end
		end
	end

	// cell array: insert on an item, shift down towards cell 0 while draining
	always_ff @(posedge clk) begin
		if (cmd.insert && !full) begin
			for (int i = 0; i < DEPTH; i++) begin
				cell_q[i] <= cell_ins[i];
			end
		end else if (cmd.shift) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				cell_q[i] <= cell_q[i + 1];
			end
		end
	end

	// fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.insert) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (cmd.shift) begin
			count_q <= count_q - CW'(1);
			if (status.last_one) begin
				dropped_q <= 1'b0;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.shift;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			sorted_value_q <= cell_q[0];
			end_of_run_q   <= status.last_one;
			overflow_q     <= dropped_q;
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = sorted_value_q;
	assign end_of_run   = end_of_run_q;
	assign overflow     = overflow_q;

endmodule

`default_nettype wire

/* rtl/insertion_sorter_top.sv */
// insertion_sorter_top: stable ascending insertion sorter, controller plus cell datapath
// depends on isrt_pkg, isrt_ctrl and isrt_dp
`timescale 1ns / 1ps
`default_nettype none

// Values are loaded one item per clock while busy is low: each accepted item is
// inserted into a compare-and-shift array of DEPTH cells, after any equal values
// already held. The item with last set ends the set; busy then rises and the
// block drains the array through cell 0, one result per cycle, smallest first;
// no item is accepted while draining. Each result is shown for one cycle with
// strobe high, the first after the last item has set the drain state and a shift
// has loaded the result registers, and must be taken then since the block cannot
// be stalled. end_of_run marks the final result. Values arriving when all DEPTH
// cells are full are dropped and every result of that set carries overflow. busy
// falls in the cycle that shows the final result, so the next set may start at
// once. Store contents are not cleared; the fill count alone tracks them.
module insertion_sorter_top #(
	parameter int DEPTH      = isrt_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = isrt_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output      logic                         busy,
	input  wire logic signed [DATA_WIDTH-1:0] value,
	input  wire logic                         last,
	output      logic                         strobe,
	output      logic signed [DATA_WIDTH-1:0] sorted_value,
	output      logic                         end_of_run,
	output      logic                         overflow
);
	import isrt_pkg::*;

	isrt_cmd_t    cmd;
	isrt_status_t status;

	// sequencing
	isrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// cells and result registers
	isrt_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.status       (status),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.end_of_run   (end_of_run),
		.overflow     (overflow)
	);

`ifndef ASSERT_OFF
	// a last item always starts a drain
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("last item did not start draining");

	// every drain cycle yields a result
	a_drain_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("drain cycle without result");

	// the final result frees the block
	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && end_of_run |-> !busy)
		else $error("still busy on final result");

	// a non-final result keeps the block draining
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !end_of_run |-> busy)
		else $error("drain ended before final result");
`endif

endmodule

`default_nettype wire
